FILE: src/size_class_block_allocator_unit_assert.svh
// Assertion macros for the size-class block allocator.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SCBA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SCBA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCBA_ASSERT_IMP(name, ante, cons, msg)
`define SCBA_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

FILE: src/scba_pkg.sv
// Package of the size-class block allocator: sizes, widths, codes and types.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps
package scba_pkg;

  localparam int unsigned PERM_BLOCK_BYTES = 65536;
  localparam int unsigned NUM_PERM_BLOCKS  = 16;
  localparam int unsigned NUM_CLASSES      = 12;

  localparam int unsigned GRAIN_BYTES        = 16;
  localparam int unsigned GRAIN_SH           = $clog2(GRAIN_BYTES);
  localparam int unsigned HEADER_BYTES       = 2;
  localparam int unsigned GRANULES_PER_BLOCK = PERM_BLOCK_BYTES / GRAIN_BYTES;
  localparam int unsigned TOTAL_GRANULES     = GRANULES_PER_BLOCK * NUM_PERM_BLOCKS;

  localparam int unsigned GOFF_W = $clog2(GRANULES_PER_BLOCK);
  localparam int unsigned GR_W   = $clog2(TOTAL_GRANULES);
  localparam int unsigned BLK_W  = (NUM_PERM_BLOCKS > 1) ? $clog2(NUM_PERM_BLOCKS) : 1;
  localparam int unsigned KW     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned OFF_W  = $clog2(PERM_BLOCK_BYTES) + 1;

  localparam int unsigned REQ_W      = 16;
  localparam int unsigned ADDR_W     = 20;
  localparam int unsigned CLS_OUT_W  = 4;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned NEED_W     = REQ_W + 1;
  localparam int unsigned SUM_W      = ((OFF_W > NEED_W) ? OFF_W : NEED_W) + 1;
  localparam int unsigned S_TDATA_W  = ((REQ_W + ADDR_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W  = ((ADDR_W + CLS_OUT_W + 7) / 8) * 8;

  typedef enum logic {
    OP_ALLOC,
    OP_FREE
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK,
    STS_TOO_LARGE,
    STS_EXHAUSTED,
    STS_BAD_FREE
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_POP,
    S_FREE,
    S_SPILL,
    S_CARVE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [GR_W-1:0] link;
    logic            live;
    logic [KW-1:0]   cls;
  } tag_entry_t;

  typedef struct packed {
    logic            we;
    logic [GR_W-1:0] waddr;
    tag_entry_t      wdata;
    logic [GR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    addr;
    logic [CLS_OUT_W-1:0] cls;
    status_e              status;
  } result_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } ctrl_status_t;

  function automatic logic [SUM_W-1:0] class_bytes(input logic [KW-1:0] k);
    return SUM_W'(GRAIN_BYTES) << k;
  endfunction

endpackage

FILE: src/scba_tag_ram.sv
// Granule memory of the allocator: free-list link, live bit and class per granule.
// Depends on scba_pkg; one write port and one read port with registered read data.
`timescale 1ns / 1ps
module scba_tag_ram import scba_pkg::*; (
  input  logic       clk_i,
  input  mem_req_t   mem_req_i,
  output tag_entry_t rdata_o
);

  tag_entry_t mem_q [TOTAL_GRANULES];
  tag_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    rdata_q <= mem_q[mem_req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/scba_ctrl.sv
// Sequencer of the allocator: decode, free-list pop and push, carving and leftover walk.
// Depends on scba_pkg; drives the granule memory and hands results to the output stage.
`timescale 1ns / 1ps
module scba_ctrl import scba_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 s_tuser_i,
  output mem_req_t             mem_req_o,
  input  tag_entry_t           mem_rdata_i,
  output logic                 res_valid_o,
  output result_t              res_o,
  input  logic                 res_ready_i,
  output ctrl_status_t         status_o
);

  localparam int unsigned BLKP_W = BLK_W + 1;

  state_e                 state_q, state_d;
  op_e                    op_q;
  logic [REQ_W-1:0]       req_q;
  logic [ADDR_W-1:0]      rel_q;
  logic [KW-1:0]          k_q, k_d;
  logic [GR_W-1:0]        g_q, g_d;
  logic [KW-1:0]          j_q, j_d;
  logic [GR_W-1:0]        clr_q, clr_d;
  logic [OFF_W-1:0]       off_q, off_d;
  logic [BLK_W-1:0]       cur_q, cur_d;
  logic                   open_q, open_d;
  logic [NUM_CLASSES-1:0] hvalid_q, hvalid_d;
  logic [GR_W-1:0]        heads_q [NUM_CLASSES];
  result_t                res_q, res_d;

  logic                   head_we;
  logic [KW-1:0]          head_idx;
  logic [GR_W-1:0]        head_val;

  logic                   accept;
  logic [NEED_W-1:0]      need;
  logic [KW-1:0]          k_sel;
  logic                   too_large;
  logic                   hit;
  logic [SUM_W-1:0]       sum_k, sum_j, sum_c;
  logic                   fits, last_blk, exhausted, spill_fits;
  logic [GR_W-1:0]        carve_g;
  logic [ADDR_W-GRAIN_SH-1:0] free_g_wide;
  logic [GR_W-1:0]        free_g;
  logic                   free_ok, live_ok;

  function automatic logic [GR_W-1:0] gran(input logic [BLK_W-1:0] b,
                                           input logic [OFF_W-1:0] o);
    return (GR_W'(b) << GOFF_W) | GR_W'(o[OFF_W-2:GRAIN_SH]);
  endfunction

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  assign need = NEED_W'(req_q) + NEED_W'(HEADER_BYTES);

  always_comb begin
    k_sel     = '0;
    too_large = 1'b1;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (class_bytes(KW'(i)) >= SUM_W'(need)) begin
        k_sel     = KW'(i);
        too_large = 1'b0;
      end
    end
  end

  assign hit        = hvalid_q[k_sel];
  assign sum_k      = SUM_W'(off_q) + class_bytes(k_sel);
  assign sum_j      = SUM_W'(off_q) + class_bytes(j_q);
  assign sum_c      = SUM_W'(off_q) + class_bytes(k_q);
  assign fits       = open_q && (sum_k <= SUM_W'(PERM_BLOCK_BYTES));
  assign last_blk   = (BLKP_W'(cur_q) + BLKP_W'(1)) >= BLKP_W'(NUM_PERM_BLOCKS);
  assign exhausted  = !fits && open_q && last_blk;
  assign spill_fits = sum_j <= SUM_W'(PERM_BLOCK_BYTES);
  assign carve_g    = gran(cur_q, off_q);

  assign free_g_wide = rel_q[ADDR_W-1:GRAIN_SH];
  assign free_g      = GR_W'(free_g_wide);
  assign free_ok     = (rel_q[GRAIN_SH-1:0] == GRAIN_SH'(HEADER_BYTES)) &&
                       (32'(free_g_wide) < 32'(TOTAL_GRANULES));
  assign live_ok     = mem_rdata_i.live && (32'(mem_rdata_i.cls) < 32'(NUM_CLASSES));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == GR_W'(TOTAL_GRANULES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (op_q == OP_ALLOC) begin
          if (too_large)      state_d = S_RESP;
          else if (hit)       state_d = S_POP;
          else if (fits)      state_d = S_CARVE;
          else if (exhausted) state_d = S_RESP;
          else if (open_q)    state_d = S_SPILL;
          else                state_d = S_CARVE;
        end else begin
          state_d = free_ok ? S_FREE : S_RESP;
        end
      end
      S_POP:   state_d = S_RESP;
      S_FREE:  state_d = S_RESP;
      S_SPILL: begin
        if (!spill_fits && (j_q == '0)) state_d = S_CARVE;
      end
      S_CARVE: state_d = S_RESP;
      S_RESP: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mem_req_o = '0;
    clr_d     = clr_q;
    k_d       = k_q;
    g_d       = g_q;
    j_d       = j_q;
    off_d     = off_q;
    cur_d     = cur_q;
    open_d    = open_q;
    hvalid_d  = hvalid_q;
    res_d     = res_q;
    head_we   = 1'b0;
    head_idx  = '0;
    head_val  = '0;
    case (state_q)
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_q;
        clr_d           = clr_q + GR_W'(1);
      end
      S_DECODE: begin
        k_d   = k_sel;
        res_d = '0;
        if (op_q == OP_ALLOC) begin
          g_d             = heads_q[k_sel];
          mem_req_o.raddr = heads_q[k_sel];
          if (too_large) begin
            res_d.status = STS_TOO_LARGE;
          end else if (!hit && !fits) begin
            if (exhausted) begin
              res_d.status = STS_EXHAUSTED;
            end else if (open_q) begin
              j_d = KW'(NUM_CLASSES - 1);
            end else begin
              open_d = 1'b1;
              cur_d  = '0;
              off_d  = '0;
            end
          end
        end else begin
          g_d             = free_g;
          mem_req_o.raddr = free_g;
          if (!free_ok) res_d.status = STS_BAD_FREE;
        end
      end
      S_POP: begin
        mem_req_o.we         = 1'b1;
        mem_req_o.waddr      = g_q;
        mem_req_o.wdata.link = mem_rdata_i.link;
        mem_req_o.wdata.live = 1'b1;
        mem_req_o.wdata.cls  = k_q;
        if (mem_rdata_i.link == g_q) begin
          hvalid_d[k_q] = 1'b0;
        end else begin
          head_we  = 1'b1;
          head_idx = k_q;
          head_val = mem_rdata_i.link;
        end
        res_d.addr = ADDR_W'({g_q, GRAIN_SH'(HEADER_BYTES)});
        res_d.cls  = CLS_OUT_W'(k_q);
      end
      S_FREE: begin
        if (live_ok) begin
          mem_req_o.we         = 1'b1;
          mem_req_o.waddr      = g_q;
          mem_req_o.wdata.link = hvalid_q[mem_rdata_i.cls] ? heads_q[mem_rdata_i.cls] : g_q;
          mem_req_o.wdata.live = 1'b0;
          mem_req_o.wdata.cls  = mem_rdata_i.cls;
          head_we  = 1'b1;
          head_idx = mem_rdata_i.cls;
          head_val = g_q;
          hvalid_d[mem_rdata_i.cls] = 1'b1;
          res_d.cls = CLS_OUT_W'(mem_rdata_i.cls);
        end else begin
          res_d.status = STS_BAD_FREE;
        end
      end
      S_SPILL: begin
        if (spill_fits) begin
          mem_req_o.we         = 1'b1;
          mem_req_o.waddr      = carve_g;
          mem_req_o.wdata.link = hvalid_q[j_q] ? heads_q[j_q] : carve_g;
          mem_req_o.wdata.live = 1'b0;
          mem_req_o.wdata.cls  = j_q;
          head_we       = 1'b1;
          head_idx      = j_q;
          head_val      = carve_g;
          hvalid_d[j_q] = 1'b1;
          off_d         = OFF_W'(sum_j);
        end else if (j_q == '0) begin
          cur_d = cur_q + BLK_W'(1);
          off_d = '0;
        end else begin
          j_d = j_q - KW'(1);
        end
      end
      S_CARVE: begin
        mem_req_o.we         = 1'b1;
        mem_req_o.waddr      = carve_g;
        mem_req_o.wdata.live = 1'b1;
        mem_req_o.wdata.cls  = k_q;
        off_d      = OFF_W'(sum_c);
        res_d.addr = ADDR_W'({carve_g, GRAIN_SH'(HEADER_BYTES)});
        res_d.cls  = CLS_OUT_W'(k_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      off_q    <= '0;
      cur_q    <= '0;
      open_q   <= 1'b0;
      hvalid_q <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      off_q    <= off_d;
      cur_q    <= cur_d;
      open_q   <= open_d;
      hvalid_q <= hvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(s_tuser_i);
      req_q <= s_tdata_i[REQ_W-1:0];
      rel_q <= s_tdata_i[REQ_W+ADDR_W-1:REQ_W];
    end
    if (head_we) begin
      heads_q[head_idx] <= head_val;
    end
    k_q   <= k_d;
    g_q   <= g_d;
    j_q   <= j_d;
    res_q <= res_d;
  end

  assign res_valid_o       = (state_q == S_RESP);
  assign res_o             = res_q;
  assign status_o.clearing = (state_q == S_CLEAR);
  assign status_o.busy     = (state_q != S_IDLE) && (state_q != S_CLEAR);

endmodule

FILE: src/scba_out_reg.sv
// Output register of the allocator: holds one result until the receiver takes it.
// Depends on scba_pkg for the result type and the stream data width.
`timescale 1ns / 1ps
module scba_out_reg import scba_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  result_t              res_i,
  output logic                 res_ready_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [M_TDATA_W-1:0] m_tdata_o,
  output logic [STATUS_W-1:0]  m_tuser_o
);

  logic    valid_q, valid_d;
  result_t data_q;
  logic    load;

  assign res_ready_o = !valid_q || m_tready_i;
  assign load        = res_valid_i && res_ready_o;
  assign valid_d     = load || (valid_q && !m_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = M_TDATA_W'({data_q.cls, data_q.addr});
  assign m_tuser_o  = data_q.status;

endmodule

FILE: src/size_class_block_allocator_unit.sv
// Top level of the size-class block allocator.
// Depends on scba_pkg, scba_tag_ram, scba_ctrl, scba_out_reg and the assertion header.
//
// Requests arrive on the s_axis channel: tuser is the operation (allocate or free),
// tdata carries the requested byte count and the address to release. Each request
// yields exactly one result on the m_axis channel: the granted user address, the
// size class and a status code (ok, too large, arena exhausted, bad free).
// When the receiver keeps up, a request runs through decode, one read of the granule
// memory, the write back with the result, and the hand-off to the output register;
// the next request is taken only after that hand-off. A request that is rejected
// at decode (too large, arena exhausted, or a malformed free address) skips the
// memory step.
// Opening a new permanent block first walks the leftover of the open one, one class
// step or one pushed piece per cycle.
// After reset the block clears the live tags of all 65536 granules, one granule per cycle,
// and takes no request until that pass ends.
// A result that the receiver stalls waits in the output register; the next request
// is taken meanwhile and then waits in its last step until the register frees.
`timescale 1ns / 1ps
`include "size_class_block_allocator_unit_assert.svh"
module size_class_block_allocator_unit import scba_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0: request_bytes[15:0], release_address[35:16], zero padding.
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // Fields from bit 0: operation[0].
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // Fields from bit 0: user_address[19:0], size_class[23:20].
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: status[1:0].
  output logic [STATUS_W-1:0]  m_axis_tuser
);

  mem_req_t     mem_req;
  tag_entry_t   mem_rdata;
  logic         res_valid;
  logic         res_ready;
  result_t      res;
  ctrl_status_t ctrl_status;

  scba_tag_ram u_tag_ram (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

  scba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .status_o    (ctrl_status)
  );

  scba_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

  `SCBA_ASSERT_IMP(a_clear_blocks_input, ctrl_status.clearing, !s_axis_tready, "request taken during clear")
  `SCBA_ASSERT_NXT(a_accept_starts_work, s_axis_tvalid && s_axis_tready, ctrl_status.busy, "accepted request not in work")
  `SCBA_ASSERT_IMP(a_error_fields_zero, m_axis_tvalid && (m_axis_tuser != STS_OK), m_axis_tdata[ADDR_W+CLS_OUT_W-1:0] == '0, "error result with nonzero fields")
  `SCBA_ASSERT_IMP(a_class_in_range, m_axis_tvalid, m_axis_tdata[ADDR_W+CLS_OUT_W-1:ADDR_W] < CLS_OUT_W'(NUM_CLASSES), "size class out of range")

endmodule

FILE: test/tb_size_class_block_allocator_unit.sv
// Self-checking testbench of the size-class block allocator (size_class_block_allocator_unit).
// Depends on scba_pkg and the block's RTL; an arena tracker predicts every result.
// Directed corner cases come first, then random alloc/free traffic under idling and stalls, then arena exhaustion.
`timescale 1ns / 1ps

import scba_pkg::*;

class arena_tracker;
  typedef struct {
    logic [ADDR_W-1:0]    addr;
    logic [CLS_OUT_W-1:0] cls;
    status_e              status;
  } grant_t;

  bit          head_valid[NUM_CLASSES];
  int unsigned head_gr[NUM_CLASSES];
  int unsigned next_gr[TOTAL_GRANULES];
  bit          is_live[TOTAL_GRANULES];
  int unsigned piece_cls[TOTAL_GRANULES];
  int unsigned carve_at;
  bit          block_open;
  int unsigned open_block;

  grant_t            pending_grants[$];
  logic [ADDR_W-1:0] live_addrs[$];
  logic [ADDR_W-1:0] freed_addrs[$];
  logic [ADDR_W-1:0] last_addr;

  int errors;
  int n_checked;
  int n_grant;
  int n_release;
  int n_too_large;
  int n_exhausted;
  int n_bad_free;
  int n_spill;

  function int unsigned piece_bytes(int unsigned k);
    return GRAIN_BYTES << k;
  endfunction

  function int unsigned granule_at(int unsigned blk, int unsigned off);
    return blk * GRANULES_PER_BLOCK + off / GRAIN_BYTES;
  endfunction

  function void push_piece(int unsigned k, int unsigned g);
    next_gr[g] = head_valid[k] ? head_gr[k] : g;
    head_gr[k] = g;
    head_valid[k] = 1'b1;
  endfunction

  function int unsigned pop_piece(int unsigned k);
    int unsigned g;
    g = head_gr[k];
    if (next_gr[g] == g) head_valid[k] = 1'b0;
    else head_gr[k] = next_gr[g];
    return g;
  endfunction

  function void spill_leftover();
    n_spill++;
    for (int j = NUM_CLASSES - 1; j >= 0; j--) begin
      while (carve_at + piece_bytes(j) <= PERM_BLOCK_BYTES) begin
        push_piece(j, granule_at(open_block, carve_at));
        carve_at += piece_bytes(j);
      end
    end
  endfunction

  function void forget_live(logic [ADDR_W-1:0] a);
    for (int i = 0; i < live_addrs.size(); i++) begin
      if (live_addrs[i] == a) begin
        live_addrs.delete(i);
        break;
      end
    end
  endfunction

  function void record_request(op_e op, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] rel);
    grant_t      r;
    int unsigned need;
    int unsigned k;
    int unsigned g;
    int unsigned sz;
    int unsigned ra;
    bit          fits;
    r.addr = '0;
    r.cls = '0;
    r.status = STS_OK;
    if (op == OP_ALLOC) begin
      need = int'(req) + HEADER_BYTES;
      k = 0;
      while (k < NUM_CLASSES && piece_bytes(k) < need) k++;
      if (k >= NUM_CLASSES) begin
        r.status = STS_TOO_LARGE;
      end else begin
        sz = piece_bytes(k);
        fits = block_open && (carve_at + sz <= PERM_BLOCK_BYTES);
        if (!head_valid[k] && !fits && block_open && open_block + 1 >= NUM_PERM_BLOCKS) begin
          r.status = STS_EXHAUSTED;
        end else begin
          if (head_valid[k]) begin
            g = pop_piece(k);
          end else begin
            if (!fits) begin
              if (block_open) begin
                spill_leftover();
                open_block++;
              end else begin
                open_block = 0;
              end
              block_open = 1'b1;
              carve_at = 0;
            end
            g = granule_at(open_block, carve_at);
            carve_at += sz;
          end
          is_live[g] = 1'b1;
          piece_cls[g] = k;
          r.addr = ADDR_W'(g * GRAIN_BYTES + HEADER_BYTES);
          r.cls = CLS_OUT_W'(k);
          live_addrs.push_back(r.addr);
          last_addr = r.addr;
        end
      end
    end else begin
      ra = int'(rel);
      if (ra < HEADER_BYTES || ((ra - HEADER_BYTES) % GRAIN_BYTES) != 0) begin
        r.status = STS_BAD_FREE;
      end else begin
        g = (ra - HEADER_BYTES) / GRAIN_BYTES;
        if (g >= TOTAL_GRANULES || !is_live[g] || piece_cls[g] >= NUM_CLASSES) begin
          r.status = STS_BAD_FREE;
        end else begin
          is_live[g] = 1'b0;
          r.cls = CLS_OUT_W'(piece_cls[g]);
          push_piece(piece_cls[g], g);
          forget_live(rel);
          freed_addrs.push_back(rel);
          if (freed_addrs.size() > 16) void'(freed_addrs.pop_front());
        end
      end
    end
    case (r.status)
      STS_OK: if (op == OP_ALLOC) n_grant++; else n_release++;
      STS_TOO_LARGE: n_too_large++;
      STS_EXHAUSTED: n_exhausted++;
      default: n_bad_free++;
    endcase
    pending_grants.push_back(r);
  endfunction

  function void check_grant(logic [ADDR_W-1:0] addr, logic [CLS_OUT_W-1:0] cls,
                            status_e status);
    grant_t e;
    n_checked++;
    if (pending_grants.size() == 0) begin
      $display("%0t: unexpected result addr %h class %0d status %s",
               $time, addr, cls, status.name());
      errors++;
      return;
    end
    e = pending_grants.pop_front();
    if (addr !== e.addr) begin
      $display("%0t: user_address mismatch, expected %h, got %h", $time, e.addr, addr);
      errors++;
    end
    if (cls !== e.cls) begin
      $display("%0t: size_class mismatch, expected %0d, got %0d", $time, e.cls, cls);
      errors++;
    end
    if (status !== e.status) begin
      $display("%0t: status mismatch, expected %s, got %s",
               $time, e.status.name(), status.name());
      errors++;
    end
  endfunction

  function int pending_count();
    return pending_grants.size();
  endfunction
endclass

module tb_size_class_block_allocator_unit;

  localparam int RANDOM_ITEMS = 1700;
  localparam int LONG_HOLD_CYCLES = 400;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;

  arena_tracker sb = new;
  bit hold_request = 1'b0;
  int long_holds = 0;
  int burst_left = 0;

  always #5 clk_i = ~clk_i;

  size_class_block_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  task automatic send_request(op_e op, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] rel);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= S_TDATA_W'({rel, req});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.record_request(op, req, rel);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= S_TDATA_W'({$urandom, $urandom});
      s_axis_tuser <= 1'($urandom_range(0, 1));
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
      idle_cycles(($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5));
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk_i);
  endtask

  function automatic logic [REQ_W-1:0] random_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return REQ_W'($urandom_range(0, 30));
    if (r < 80) return REQ_W'($urandom_range(31, 510));
    if (r < 92) return REQ_W'($urandom_range(511, 4094));
    if (r < 96) return REQ_W'($urandom_range(4095, 32766));
    if (r < 98) return REQ_W'($urandom_range(32767, 65535));
    return REQ_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [ADDR_W-1:0] random_release();
    int unsigned r;
    int n_live;
    n_live = sb.live_addrs.size();
    r = $urandom_range(0, 99);
    if (r < 75 && n_live > 0) return sb.live_addrs[$urandom_range(0, n_live - 1)];
    if (r < 85 && sb.freed_addrs.size() > 0)
      return sb.freed_addrs[$urandom_range(0, sb.freed_addrs.size() - 1)];
    if (r < 92 && n_live > 0)
      return ADDR_W'(sb.live_addrs[$urandom_range(0, n_live - 1)] +
                     GRAIN_BYTES * $urandom_range(1, 3));
    return ADDR_W'($urandom);
  endfunction

  task automatic random_request();
    int free_pct;
    int n_live;
    n_live = sb.live_addrs.size();
    free_pct = (n_live < 8) ? 20 : (n_live > 64) ? 70 : 45;
    if ($urandom_range(0, 99) < free_pct)
      send_request(OP_FREE, REQ_W'($urandom), random_release());
    else
      send_request(OP_ALLOC, random_size(), ADDR_W'($urandom));
  endtask

  // Receiver: cycles through always-ready, random and mostly-stalled stretches,
  // plus one long hold-off on request so that the block backs up into its input.
  initial begin
    int cyc;
    cyc = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
        long_holds++;
      end else begin
        case ((cyc / 500) % 4)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 9) < 7);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= cyc[0] | cyc[2];
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_grant(m_axis_tdata[ADDR_W-1:0], m_axis_tdata[ADDR_W+CLS_OUT_W-1:ADDR_W],
                     status_e'(m_axis_tuser));
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] first_small;
    logic [ADDR_W-1:0] first_big;
    int exhausted_at;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners: class boundaries, every class, too-large requests,
    // a spill of the open block, LIFO reuse and each kind of bad free.
    send_request(OP_ALLOC, 0, '0);
    first_small = sb.last_addr;
    send_request(OP_ALLOC, 14, '1);
    send_request(OP_ALLOC, 15, '0);
    send_request(OP_ALLOC, 32766, '0);
    first_big = sb.last_addr;
    send_request(OP_ALLOC, 32767, '0);
    send_request(OP_ALLOC, 16'hFFFF, '1);
    for (int k = 2; k < NUM_CLASSES - 1; k++) begin
      send_request(OP_ALLOC, REQ_W'((GRAIN_BYTES << k) - HEADER_BYTES), '0);
      pace();
    end
    send_request(OP_ALLOC, 32766, '0);
    send_request(OP_FREE, '1, first_small);
    send_request(OP_FREE, '0, first_small);
    send_request(OP_ALLOC, 1, '0);
    send_request(OP_FREE, '0, 0);
    send_request(OP_FREE, '0, 1);
    send_request(OP_FREE, '0, 3);
    send_request(OP_FREE, '0, '1);
    send_request(OP_FREE, '0, 20'hFFFF2);
    send_request(OP_FREE, '0, first_big + GRAIN_BYTES);
    send_request(OP_FREE, '0, first_big);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) hold_request = 1'b1;
      if (n == 900) drain_results();
      random_request();
      pace();
    end
    drain_results();

    // Use up the arena with largest-class requests, then check that the
    // leftover still serves small ones and that freed pieces come back.
    exhausted_at = sb.n_exhausted;
    for (int n = 0; n < 80 && sb.n_exhausted < exhausted_at + 3; n++) begin
      send_request(OP_ALLOC, 32766, ADDR_W'($urandom));
      pace();
    end
    for (int n = 0; n < 10; n++) begin
      send_request(OP_ALLOC, REQ_W'($urandom_range(0, 200)), '0);
      pace();
    end
    for (int n = 0; n < 20 && sb.live_addrs.size() > 0; n++) begin
      send_request(OP_FREE, '0, sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)]);
      pace();
    end
    for (int n = 0; n < 6; n++) begin
      send_request(OP_ALLOC, 32766, '0);
      pace();
    end

    drain_results();
    repeat (50) @(posedge clk_i);
    $display("Checked %0d results: %0d grants, %0d frees, %0d too large, %0d exhausted,",
             sb.n_checked, sb.n_grant, sb.n_release, sb.n_too_large, sb.n_exhausted);
    $display("%0d bad frees, %0d leftover spills, %0d long receiver hold-offs.",
             sb.n_bad_free, sb.n_spill, long_holds);
    if (sb.errors == 0 && sb.pending_count() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
